FILE: hw/rtl/positional_ordered_list_defines.svh
// Assertion macros for the positional ordered list RTL.
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// Invariant checked on every clock edge outside reset.
`define POL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("positional_ordered_list: invariant violated");

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define POL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional_ordered_list: next-cycle check failed");

`endif

FILE: hw/rtl/pol_pkg.sv
// Shared constants, codes and types for the positional ordered list.
package pol_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 3;
  localparam int POS_W       = 5;
  localparam int IDX_FW      = 5;
  localparam int STAT_W      = 2;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [IDX_FW-1:0] NOT_FOUND = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_EMPTY  = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Per-cell update command.
  typedef struct packed {
    logic load;       // take the incoming item value
    logic take_prev;  // shift up: take lower neighbor
    logic take_next;  // shift down: take upper neighbor
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/positional_ordered_list.sv
// Top level of the positional ordered list: control, cell row, result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | action_i, value_i, position_i
//  out     | output    | out_valid_o / out_stall_i | found_index_o, is_empty_o,
//          |           |                           | status_o, entry_count_o
//
//  One item per clock while in_stall_o is low: every item is resolved in the cycle
//  it is accepted and its result lands in the output register on that edge. Insert
//  and remove shift the whole cell row in that one cycle; search compares all cells
//  in parallel and a priority pick over the cell row gives the first match.
//  Reset (rst_ni low, asynchronous) empties the list and drops any pending result.
//  in_stall_o is high only while a result sits in the output register and out
//  stalls; the cell row and count then hold.

`include "positional_ordered_list_defines.svh"

module positional_ordered_list import pol_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // item input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [IDX_FW-1:0] found_index_o,
  output logic                     is_empty_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [IDX_FW-1:0]        entry_count_o
);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_acc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------------
  // Fill count
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             full;
  logic             empty;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(position_i);
  assign full    = (count_q == CNT_W'(MAX_ENTRIES));
  assign empty   = (count_q == '0);

  // ---------------------------------------------------------------------------
  // Action decode: decides shift direction, split point and status
  // ---------------------------------------------------------------------------
  logic             do_ins;
  logic             do_rem;
  logic [CMP_W-1:0] split_pos;
  status_e          status_d;

  always_comb begin
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    split_pos = pos_ext;
    status_d  = ST_OK;
    unique case (action_i)
      ACT_APPEND: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins    = 1'b1;
          split_pos = cnt_ext;
        end
      end
      ACT_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (empty) begin
          // empty list: position is ignored, value goes to the head
          do_ins    = 1'b1;
          split_pos = '0;
        end else if (pos_ext > cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (in_acc && do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (in_acc && do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   cell_match;
  logic [MAX_ENTRIES-1:0]   hit;

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] prev_data;
    logic signed [DATA_W-1:0] next_data;

    // insert: cells above the split take the lower neighbor, split cell loads
    // remove: cells from the split upward take the upper neighbor
    assign ctrl.load      = in_acc & do_ins & (CMP_W'(gi) == split_pos);
    assign ctrl.take_prev = in_acc & do_ins & (CMP_W'(gi) > split_pos);
    assign ctrl.take_next = in_acc & do_rem & (CMP_W'(gi) >= split_pos);

    if (gi == 0) begin : g_head
      assign prev_data = '0;
    end else begin : g_body
      assign prev_data = cell_data[gi-1];
    end

    if (gi == MAX_ENTRIES - 1) begin : g_tail
      assign next_data = cell_data[gi];
    end else begin : g_inner
      assign next_data = cell_data[gi+1];
    end

    pol_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[gi]),
      .match_o (cell_match[gi])
    );

    // only live entries may report a hit
    assign hit[gi] = cell_match[gi] & (CNT_W'(gi) < count_q);
  end

  // First hit wins: scan from the top so the lowest index is kept.
  logic [IDX_FW-1:0] found_d;

  always_comb begin
    found_d = NOT_FOUND;
    if (action_i == ACT_SEARCH) begin
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
        if (hit[i]) begin
          found_d = IDX_FW'(i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [IDX_FW-1:0] found_q;
  logic              is_empty_q;
  status_e           status_q;
  logic [IDX_FW-1:0] entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload: captured on every accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      found_q       <= found_d;
      is_empty_q    <= (count_d == '0);
      status_q      <= status_d;
      entry_count_q <= IDX_FW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_index_o = found_q;
  assign is_empty_o    = is_empty_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `POL_ASSERT(a_count_range, count_q <= CNT_W'(MAX_ENTRIES))
  `POL_ASSERT_NEXT(a_full_holds, in_acc && (status_d == ST_FULL), count_q == $past(count_q))
  `POL_ASSERT_NEXT(a_empty_matches_count, in_acc, is_empty_q == (count_q == '0))
  `POL_ASSERT_NEXT(a_nonsearch_not_found, in_acc && (action_i != ACT_SEARCH),
                   found_q == NOT_FOUND)

endmodule

FILE: hw/rtl/pol_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares on search.
module pol_cell import pol_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] prev_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     match_o
);

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.take_prev) begin
      data_d = prev_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_i;
    end
  end

  // Entry storage; contents are meaningless until written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule
